// ----- src/alu_add_sub_inc_dec_flags_top_defines.svh -----
// Assertion macros shared by the ALU block's modules.
`ifndef ALU_ADD_SUB_INC_DEC_FLAGS_TOP_DEFINES_SVH
`define ALU_ADD_SUB_INC_DEC_FLAGS_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define ASID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define ASID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/alu_asid_pkg.sv -----
// Shared types and constants of the ALU block.
package alu_asid_pkg;

    localparam int NUM_REGS        = 7;
    localparam int REG_W           = 3;
    localparam int DATA_W          = 8;
    localparam int CMD_W           = 3;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [REG_W-1:0] REG_A = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_REG = 3'd0,
        CMD_ADD_IMM = 3'd1,
        CMD_SUB_REG = 3'd2,
        CMD_SUB_IMM = 3'd3,
        CMD_INC     = 3'd4,
        CMD_DEC     = 3'd5,
        CMD_LOAD    = 3'd6,
        CMD_NONE    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_INC,
        OP_DEC,
        OP_LOAD,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              use_imm;
        logic [REG_W-1:0]  sel;
        logic [DATA_W-1:0] imm;
    } uop_t;

    // Packed highest bit first: carry sits at the top of the result word.
    typedef struct packed {
        logic cy;
        logic p;
        logic ac;
        logic z;
        logic s;
    } flags_t;

    typedef struct packed {
        flags_t            flags;
        logic [REG_W-1:0]  dest;
        logic [DATA_W-1:0] value;
    } result_t;

endpackage

// ----- src/alu_asid_front.sv -----
// Front end: accept instruction words and decode them into queue entries.
module alu_asid_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [alu_asid_pkg::CMD_W-1:0]   s_tuser,
    input  logic [alu_asid_pkg::REG_W-1:0]   s_sel,
    input  logic [alu_asid_pkg::DATA_W-1:0]  s_imm,
    input  logic                             q_ready_i,
    output logic                             push_o,
    output alu_asid_pkg::uop_t               push_data_o
);
    import alu_asid_pkg::*;

    cmd_t cmd;
    logic sel_ok;

    assign cmd      = cmd_t'(s_tuser);
    assign sel_ok   = s_sel < REG_W'(NUM_REGS);
    assign s_tready = q_ready_i;
    assign push_o   = s_tvalid & q_ready_i;

    always_comb begin
        push_data_o.op      = OP_NOP;
        push_data_o.use_imm = 1'b0;
        push_data_o.sel     = s_sel;
        push_data_o.imm     = s_imm;
        unique case (cmd)
            CMD_ADD_REG: begin
                push_data_o.op = sel_ok ? OP_ADD : OP_NOP;
            end
            CMD_ADD_IMM: begin
                push_data_o.op      = OP_ADD;
                push_data_o.use_imm = 1'b1;
                push_data_o.sel     = REG_A;
            end
            CMD_SUB_REG: begin
                push_data_o.op = sel_ok ? OP_SUB : OP_NOP;
            end
            CMD_SUB_IMM: begin
                push_data_o.op      = OP_SUB;
                push_data_o.use_imm = 1'b1;
                push_data_o.sel     = REG_A;
            end
            CMD_INC: begin
                push_data_o.op = sel_ok ? OP_INC : OP_NOP;
            end
            CMD_DEC: begin
                push_data_o.op = sel_ok ? OP_DEC : OP_NOP;
            end
            CMD_LOAD: begin
                push_data_o.op = sel_ok ? OP_LOAD : OP_NOP;
            end
            CMD_NONE: begin
                push_data_o.op = OP_NOP;
            end
        endcase
    end

endmodule

// ----- src/alu_asid_queue.sv -----
// Short FIFO of decoded instructions between front end and execute stage.
`include "alu_add_sub_inc_dec_flags_top_defines.svh"

module alu_asid_queue #(
    parameter int DEPTH = alu_asid_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_i,
    input  alu_asid_pkg::uop_t push_data_i,
    output logic               in_ready_o,
    input  logic               pop_i,
    output logic               out_valid_o,
    output alu_asid_pkg::uop_t out_data_o
);
    import alu_asid_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uop_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign in_ready_o  = aresetn && (count_reg != CNT_W'(DEPTH));
    assign out_valid_o = count_reg != '0;
    assign out_data_o  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_i) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push_i, pop_i})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            slot_reg[wr_ptr_reg] <= push_data_i;
        end
    end

    `ASID_ASSERT_NOW(a_q_no_pop_empty, pop_i, count_reg != '0, "queue popped while empty")
    `ASID_ASSERT_NOW(a_q_no_push_full, push_i, count_reg != CNT_W'(DEPTH), "queue pushed while full")
    `ASID_ASSERT_NOW(a_q_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// ----- src/alu_asid_exec.sv -----
// Execute stage: register file, flags, ALU and output register.
`include "alu_add_sub_inc_dec_flags_top_defines.svh"

module alu_asid_exec (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid_i,
    input  alu_asid_pkg::uop_t    q_data_i,
    output logic                  pop_o,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output alu_asid_pkg::result_t m_data_o
);
    import alu_asid_pkg::*;

    logic [DATA_W-1:0] rf_reg [NUM_REGS];
    flags_t            flags_reg, flags_next;
    logic              m_valid_reg;
    result_t           out_reg, out_next;

    logic              sel_ok;
    logic              is_step;
    logic              is_sub;
    logic              wr_en;
    logic [DATA_W-1:0] rd_sel;
    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic [3:0]        neg_lo;
    logic [3:0]        b_lo;
    logic [4:0]        lo_sum;
    logic [DATA_W:0]   wide;
    flags_t            alu_flags;

    assign pop_o    = q_valid_i && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_data_o = out_reg;

    assign sel_ok  = q_data_i.sel < REG_W'(NUM_REGS);
    assign rd_sel  = sel_ok ? rf_reg[q_data_i.sel] : '0;
    assign is_step = (q_data_i.op == OP_INC) || (q_data_i.op == OP_DEC);
    assign is_sub  = (q_data_i.op == OP_SUB) || (q_data_i.op == OP_DEC);

    assign a_val = is_step ? rd_sel : rf_reg[REG_A];
    assign b_val = q_data_i.use_imm ? q_data_i.imm
                 : (is_step ? DATA_W'(1) : rd_sel);

    // Subtract takes the aux carry from adding the low nibble of -b.
    assign neg_lo = 4'(~b_val[3:0] + 4'd1);
    assign b_lo   = is_sub ? neg_lo : b_val[3:0];
    assign lo_sum = {1'b0, a_val[3:0]} + {1'b0, b_lo};
    assign wide   = is_sub ? ({1'b0, a_val} - {1'b0, b_val})
                           : ({1'b0, a_val} + {1'b0, b_val});

    always_comb begin
        alu_flags.s  = wide[DATA_W-1];
        alu_flags.z  = wide[DATA_W-1:0] == '0;
        alu_flags.ac = lo_sum[4];
        alu_flags.p  = ~^wide[DATA_W-1:0];
        alu_flags.cy = is_step ? flags_reg.cy : wide[DATA_W];
    end

    always_comb begin
        wr_en          = 1'b0;
        flags_next     = flags_reg;
        out_next.value = rf_reg[REG_A];
        out_next.dest  = REG_A;
        unique case (q_data_i.op)
            OP_ADD, OP_SUB: begin
                wr_en          = 1'b1;
                flags_next     = alu_flags;
                out_next.value = wide[DATA_W-1:0];
            end
            OP_INC, OP_DEC: begin
                wr_en          = 1'b1;
                flags_next     = alu_flags;
                out_next.value = wide[DATA_W-1:0];
                out_next.dest  = q_data_i.sel;
            end
            OP_LOAD: begin
                wr_en          = 1'b1;
                out_next.value = q_data_i.imm;
                out_next.dest  = q_data_i.sel;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        out_next.flags = flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                rf_reg[i] <= '0;
            end
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop_o) begin
                if (wr_en) begin
                    rf_reg[out_next.dest] <= out_next.value;
                end
                flags_reg   <= flags_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_o) begin
            out_reg <= out_next;
        end
    end

    `ASID_ASSERT_NEXT(a_ex_step_keeps_cy, pop_o && is_step, flags_reg.cy == $past(flags_reg.cy), "carry changed on increment or decrement")
    `ASID_ASSERT_NEXT(a_ex_nop_keeps_a, pop_o && (q_data_i.op == OP_NOP), rf_reg[0] == $past(rf_reg[0]), "no-op changed register A")

endmodule

// ----- src/alu_add_sub_inc_dec_flags_top.sv -----
// Top level of the 8-bit ALU with seven-register file and five flags.
// Usage:
//   Input channel (s_*): one instruction per word. s_tuser carries the command
//   (add reg, add imm, sub reg, sub imm, increment, decrement, load, no-op);
//   s_tdata carries the register select and the immediate byte.
//   Result channel (m_*): one word per instruction with the value written (for
//   a no-op, reg A), the destination register and the five flags after it.
//   Throughput: one word per cycle, sustained, as long as m_tready is high.
//   Path: an accepted word is written into the decode queue; the execute
//   stage then pops it and loads the output register, which drives
//   m_tvalid.
//   The execute stage reads and writes the register file in the same cycle,
//   so consecutive dependent instructions issue back to back.
//   Stall: while m_tready is low the output register holds its word; the
//   decode queue keeps taking words until it is full, then s_tready drops.
//   Reset: aresetn low clears the register file, the flags, the queue and
//   m_tvalid; s_tready stays low during reset.
module alu_add_sub_inc_dec_flags_top #(
    parameter int QUEUE_DEPTH = alu_asid_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] cmd
    input  logic [alu_asid_pkg::CMD_W-1:0]       s_tuser,
    // [2:0] reg_select, [10:3] immediate, [15:11] zero
    input  logic [alu_asid_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] result, [10:8] dest_reg, [11] sign_flag, [12] zero_flag,
    // [13] aux_carry_flag, [14] parity_flag, [15] carry_flag
    output logic [alu_asid_pkg::M_TDATA_W-1:0]   m_tdata
);
    import alu_asid_pkg::*;

    // Front to queue
    logic    q_ready;
    logic    push;
    uop_t    push_data;
    // Queue to execute
    logic    q_valid;
    uop_t    q_data;
    logic    pop;
    result_t m_data;

    // Split the input word into its fields.
    alu_asid_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_sel       (s_tdata[REG_W-1:0]),
        .s_imm       (s_tdata[REG_W+DATA_W-1:REG_W]),
        .q_ready_i   (q_ready),
        .push_o      (push),
        .push_data_o (push_data)
    );

    // Decouple decode from execute so either side can stall alone.
    alu_asid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .push_data_i (push_data),
        .in_ready_o  (q_ready),
        .pop_i       (pop),
        .out_valid_o (q_valid),
        .out_data_o  (q_data)
    );

    // Execute and hold the result word until taken.
    alu_asid_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid_i (q_valid),
        .q_data_i  (q_data),
        .pop_o     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data_o  (m_data)
    );

    // result_t packs exactly into the 16-bit output word.
    assign m_tdata = M_TDATA_W'(m_data);

endmodule
